// ----- design/assert_macros.svh -----
// Assertion helpers included by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checks that a condition never holds outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);

`endif

// ----- design/pida_pkg.sv -----
package pida_pkg;

    localparam int DEPTH = 32;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_DUMP   = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    typedef logic [1:0] cell_cmd_t;

    localparam cell_cmd_t CMD_HOLD   = 2'd0;
    localparam cell_cmd_t CMD_INSERT = 2'd1;
    localparam cell_cmd_t CMD_DELETE = 2'd2;
    localparam cell_cmd_t CMD_ROTATE = 2'd3;

    typedef struct packed {
        cell_cmd_t          cmd;
        logic [6:0]         pos;
        logic [6:0]         cnt;
        logic signed [31:0] value;
    } cell_ctrl_t;

endpackage

// ----- design/pida_cell.sv -----
module pida_cell import pida_pkg::*; (
    input  logic               aclk,
    input  cell_ctrl_t         ctrl,
    input  logic [IDX_W-1:0]   cell_idx,
    input  logic signed [31:0] left_data,
    input  logic signed [31:0] right_data,
    input  logic signed [31:0] head_data,
    output logic signed [31:0] data_q
);

    logic signed [31:0] word_reg;
    logic signed [31:0] word_next;
    logic [6:0]         idx7;

    assign idx7   = 7'(cell_idx);
    assign data_q = word_reg;

    always_comb begin
        word_next = word_reg;
        unique case (ctrl.cmd)
            CMD_INSERT: begin
                if (idx7 > ctrl.pos) begin
                    word_next = left_data;
                end else if (idx7 == ctrl.pos) begin
                    word_next = ctrl.value;
                end
            end
            CMD_DELETE: begin
                if (idx7 >= ctrl.pos) begin
                    word_next = right_data;
                end
            end
            CMD_ROTATE: begin
                if ((idx7 + 7'd1) == ctrl.cnt) begin
                    word_next = head_data;
                end else begin
                    word_next = right_data;
                end
            end
            default: begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

endmodule

// ----- design/positional_insert_delete_array_top.sv -----
// Ordered list of up to DEPTH signed words held in a row of cells. Insert, delete and
// unused opcodes give one result each; a successful insert or delete shifts the cells
// from its position onward in the cycle it is accepted. A dump gives one result per
// stored entry, one per cycle while the output register is free, read from the head
// cell while the row rotates, and holds off new input until its last result is loaded;
// its accepting cycle loads no result, and an empty list gives a single ST_EMPTY result.
// Results wait in an output register, and a new transfer is taken in the cycle that register is freed.
`include "assert_macros.svh"

module positional_insert_delete_array_top import pida_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // Fields from bit 0: value[31:0], position[37:32], zero fill.
    input  logic [39:0] s_tdata,
    // Fields from bit 0: opcode[1:0].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // Fields from bit 0: entry_index[5:0], entry_value[37:6], count_now[44:38], zero fill.
    output logic [47:0] m_tdata,
    // Fields from bit 0: status[1:0].
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_DUMP = 1'b1;

    logic               state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   dump_idx_reg, dump_idx_next;
    logic               ov_reg, ov_next;
    logic [1:0]         o_status_reg, o_status_next;
    logic [5:0]         o_index_reg, o_index_next;
    logic signed [31:0] o_value_reg, o_value_next;
    logic [6:0]         o_count_reg, o_count_next;
    logic               o_last_reg, o_last_next;

    logic               slot_free;
    logic               in_fire;
    logic [1:0]         in_op;
    logic signed [31:0] in_value;
    logic [6:0]         in_pos7;
    logic [6:0]         cnt7;
    logic               is_full;
    logic               is_empty;
    logic               dump_last;
    logic               ins_ok;
    cell_ctrl_t         ctrl;

    logic signed [31:0] cell_q [DEPTH];

    assign slot_free = !ov_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && slot_free;
    assign in_fire   = s_tvalid && s_tready;
    assign in_op     = s_tuser;
    assign in_value  = s_tdata[31:0];
    assign in_pos7   = {1'b0, s_tdata[37:32]};
    assign cnt7      = 7'(count_reg);
    assign is_full   = (cnt7 == 7'(DEPTH));
    assign is_empty  = (count_reg == '0);
    assign dump_last = ((7'(dump_idx_reg) + 7'd1) == cnt7);
    assign ins_ok    = in_fire && (in_op == OP_INSERT) && !is_full && (in_pos7 <= cnt7);

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        dump_idx_next = dump_idx_reg;
        ov_next       = ov_reg && !m_tready;
        o_status_next = o_status_reg;
        o_index_next  = o_index_reg;
        o_value_next  = o_value_reg;
        o_count_next  = o_count_reg;
        o_last_next   = o_last_reg;
        ctrl.cmd      = CMD_HOLD;
        ctrl.pos      = in_pos7;
        ctrl.cnt      = cnt7;
        ctrl.value    = in_value;

        unique case (state_reg)
            S_IDLE: begin
                if (in_fire) begin
                    ov_next       = 1'b1;
                    o_status_next = ST_OK;
                    o_index_next  = '0;
                    o_value_next  = '0;
                    o_count_next  = cnt7;
                    o_last_next   = 1'b1;
                    case (in_op)
                        OP_INSERT: begin
                            if (is_full) begin
                                o_status_next = ST_FULL;
                            end else if (in_pos7 > cnt7) begin
                                o_status_next = ST_BADPOS;
                            end else begin
                                ctrl.cmd     = CMD_INSERT;
                                count_next   = count_reg + CNT_W'(1);
                                o_count_next = cnt7 + 7'd1;
                            end
                        end
                        OP_DELETE: begin
                            if (is_empty) begin
                                o_status_next = ST_EMPTY;
                            end else if (in_pos7 >= cnt7) begin
                                o_status_next = ST_BADPOS;
                            end else begin
                                ctrl.cmd     = CMD_DELETE;
                                count_next   = count_reg - CNT_W'(1);
                                o_count_next = cnt7 - 7'd1;
                            end
                        end
                        OP_DUMP: begin
                            if (is_empty) begin
                                o_status_next = ST_EMPTY;
                            end else begin
                                ov_next       = ov_reg && !m_tready;
                                state_next    = S_DUMP;
                                dump_idx_next = '0;
                            end
                        end
                        default: begin
                            o_status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_DUMP: begin
                if (slot_free) begin
                    ctrl.cmd      = CMD_ROTATE;
                    ov_next       = 1'b1;
                    o_status_next = ST_OK;
                    o_index_next  = 6'(dump_idx_reg);
                    o_value_next  = cell_q[0];
                    o_count_next  = cnt7;
                    o_last_next   = dump_last;
                    dump_idx_next = dump_idx_reg + IDX_W'(1);
                    if (dump_last) begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        pida_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .cell_idx   (IDX_W'(i)),
            .left_data  (cell_q[(i == 0) ? 0 : i - 1]),
            .right_data (cell_q[(i == DEPTH - 1) ? i : i + 1]),
            .head_data  (cell_q[0]),
            .data_q     (cell_q[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            dump_idx_reg <= '0;
            ov_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            dump_idx_reg <= dump_idx_next;
            ov_reg       <= ov_next;
        end
        o_status_reg <= o_status_next;
        o_index_reg  <= o_index_next;
        o_value_reg  <= o_value_next;
        o_count_reg  <= o_count_next;
        o_last_reg   <= o_last_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = {3'b000, o_count_reg, o_value_reg, o_index_reg};
    assign m_tuser  = o_status_reg;
    assign m_tlast  = o_last_reg;

    `ASSERT_NEVER(a_count_range, (cnt7 > 7'(DEPTH)), "entry count exceeds depth")
    `ASSERT_NEVER(a_dump_nonempty, (state_reg == S_DUMP) && is_empty, "dump of an empty list")
    `ASSERT_NEVER(a_no_input_in_dump, (state_reg == S_DUMP) && s_tready, "input taken during dump")
    `ASSERT_CLK(a_insert_count, ins_ok |=> (count_reg == $past(count_reg) + CNT_W'(1)), "insert did not grow count")

endmodule
